// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the step command checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/vsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vsc_pkg
// Types and constants of the velocity to step command converter.
// ----------------------------------------------------------------------------
package vsc_pkg;

    localparam int CHAN_W  = 2;
    localparam int VEL_W   = 28;
    localparam int LEN_W   = 4;
    localparam int CFG_W   = 8;
    localparam int MAG_W   = 26;
    localparam int FMAX_W  = 20;
    localparam int DEN_W   = MAG_W + FMAX_W;
    localparam int NUM_W   = 52;
    localparam int QUO_W   = 19;
    localparam int PAUSE_W = 17;
    localparam int WORD_W  = 32;
    localparam int NUM_REGS = 4;

    // full scale 1000 in Q11.16
    localparam logic [MAG_W-1:0]   MAG_FULL_SCALE = 26'd65536000;
    localparam logic [LEN_W-1:0]   LEN_MAX        = 4'd15;
    localparam logic [PAUSE_W-1:0] PAUSE_MAX      = 17'h1FFFF;
    // 65536000 * 1e9 / 20: pause + 50*len = floor(this / (fmax * mag))
    localparam logic [NUM_W-1:0]   DIV_NUMERATOR  = 52'd3276800000000000;

    // floor(1e6 / len) for len 0..15; a len 0 quotient is never used
    localparam logic [FMAX_W-1:0] FMAX_TABLE [16] = '{
        20'd0,      20'd1000000, 20'd500000, 20'd333333,
        20'd250000, 20'd200000,  20'd166666, 20'd142857,
        20'd125000, 20'd111111,  20'd100000, 20'd90909,
        20'd83333,  20'd76923,   20'd71428,  20'd66666
    };

    // per-request control that rides along the pipeline
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              dir;
        logic [LEN_W-1:0]  len;
        logic              zero;   // zero velocity or zero pulse length
    } meta_t;

endpackage

// ===== hdl/velocity_to_step_command.sv =====
// Path: stage A, product, divider stages, final stage, output register.
// Throughput: one request per cycle while not stalled; the 19-stage divider
//   takes one quotient bit per stage, each stage a full pipeline register.
// Output side holds an output register plus a skid entry; input stalls only
//   when both are full.
// Reset: rst_n async active low clears valid bits and pulse length registers.
// ----------------------------------------------------------------------------
// velocity_to_step_command
// Converts a signed Q11.16 velocity request into a step/dir command word.
// ----------------------------------------------------------------------------
module velocity_to_step_command
    import vsc_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // [27:0] velocity
    input  logic [CHAN_W-1:0]   s_axis_tuser,   // [1:0] channel
    // output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [WORD_W-1:0]   m_axis_tdata,   // [31:0] command_word
    output logic [CHAN_W-1:0]   m_axis_tuser    // [1:0] channel_out
);

    // pulse length registers
    logic [CFG_W-1:0] pulse_len_reg [NUM_CHANNELS];

    // pipeline control
    logic adv;

    // stage A: lookup and magnitude
    logic              a_vld_reg;
    meta_t             a_meta_reg,  a_meta_next;
    logic [MAG_W-1:0]  a_mag_reg,   a_mag_next;
    logic [FMAX_W-1:0] a_fmax_reg,  a_fmax_next;
    logic [CFG_W-1:0]  raw_len;
    logic [VEL_W-1:0]  vel;
    logic [VEL_W-1:0]  vel_abs;

    // divider stages, index 0 holds the product
    logic              div_vld_reg  [QUO_W+1];
    meta_t             div_meta_reg [QUO_W+1];
    logic [NUM_W-1:0]  div_rem_reg  [QUO_W+1];
    logic [DEN_W-1:0]  div_den_reg  [QUO_W+1];
    logic [QUO_W-1:0]  div_quo_reg  [QUO_W+1];
    logic [NUM_W-1:0]  div_rem_next [QUO_W];
    logic [QUO_W-1:0]  div_quo_next [QUO_W];

    // final formatting stage
    logic              f_vld_reg;
    logic [CHAN_W-1:0] f_chan_reg;
    logic [WORD_W-1:0] f_word_reg, f_word_next;
    logic [QUO_W-2:0]  pause_raw;
    logic [9:0]        len_x50;
    meta_t             f_meta;
    logic [QUO_W-1:0]  f_quo;

    // output register and skid entry
    logic              out_vld_reg,  skid_vld_reg;
    logic [CHAN_W-1:0] out_chan_reg, skid_chan_reg;
    logic [WORD_W-1:0] out_word_reg, skid_word_reg;
    logic              out_take;

    // ------------------------------------------------------------------
    // configuration writes, indexes beyond the channel count are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pulse_len_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (cfg_index == 2'(i))
                begin
                    pulse_len_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // the whole pipeline moves while the skid entry is free
    assign adv           = !skid_vld_reg;
    assign s_axis_tready = adv;

    // ------------------------------------------------------------------
    // stage A: channel lookup, clamp, magnitude, fmax table
    always_comb
    begin
        raw_len = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (s_axis_tuser == 2'(i))
            begin
                raw_len = pulse_len_reg[i];
            end
        end
        a_meta_next.chan = s_axis_tuser;
        a_meta_next.len  = (raw_len > CFG_W'(LEN_MAX)) ? LEN_MAX : raw_len[LEN_W-1:0];

        vel     = s_axis_tdata[VEL_W-1:0];
        vel_abs = vel[VEL_W-1] ? (~vel + VEL_W'(1)) : vel;
        a_meta_next.dir  = vel[VEL_W-1];
        a_meta_next.zero = (vel == '0) || (a_meta_next.len == '0);
        a_mag_next  = (vel_abs > VEL_W'(MAG_FULL_SCALE)) ? MAG_FULL_SCALE
                                                         : vel_abs[MAG_W-1:0];
        a_fmax_next = FMAX_TABLE[a_meta_next.len];
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage, msb first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int SH = QUO_W - 1 - k;
        logic [63:0] den_sh;
        logic [63:0] rem_ext;
        logic        ge;

        always_comb
        begin
            den_sh  = {{(64-DEN_W){1'b0}}, div_den_reg[k]} << SH;
            rem_ext = {{(64-NUM_W){1'b0}}, div_rem_reg[k]};
            ge      = rem_ext >= den_sh;
            div_rem_next[k]     = ge ? (div_rem_reg[k] - den_sh[NUM_W-1:0])
                                     : div_rem_reg[k];
            div_quo_next[k]     = div_quo_reg[k];
            div_quo_next[k][SH] = ge;
        end
    end

    // ------------------------------------------------------------------
    // final stage: remove the pulse time, saturate, pack the word
    always_comb
    begin
        f_meta    = div_meta_reg[QUO_W];
        f_quo     = div_quo_reg[QUO_W];
        len_x50   = 10'(f_meta.len) * 10'd50;
        pause_raw = f_quo[QUO_W-2:0] - (QUO_W-1)'(len_x50);
        f_word_next = '0;
        f_word_next[27:24] = f_meta.len;
        if (!f_meta.zero)
        begin
            f_word_next[31] = f_meta.dir;
            if (f_quo[QUO_W-1] || pause_raw[QUO_W-2])
            begin
                f_word_next[PAUSE_W-1:0] = PAUSE_MAX;
            end
            else
            begin
                f_word_next[30]          = 1'b1;
                f_word_next[PAUSE_W-1:0] = pause_raw[PAUSE_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            for (int i = 0; i <= QUO_W; i++)
            begin
                div_vld_reg[i] <= 1'b0;
            end
            f_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg      <= s_axis_tvalid;
            div_vld_reg[0] <= a_vld_reg;
            for (int i = 1; i <= QUO_W; i++)
            begin
                div_vld_reg[i] <= div_vld_reg[i-1];
            end
            f_vld_reg <= div_vld_reg[QUO_W];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_meta_reg <= a_meta_next;
            a_mag_reg  <= a_mag_next;
            a_fmax_reg <= a_fmax_next;

            div_meta_reg[0] <= a_meta_reg;
            div_rem_reg[0]  <= DIV_NUMERATOR;
            div_den_reg[0]  <= DEN_W'(a_fmax_reg) * DEN_W'(a_mag_reg);
            div_quo_reg[0]  <= '0;
            for (int i = 1; i <= QUO_W; i++)
            begin
                div_meta_reg[i] <= div_meta_reg[i-1];
                div_den_reg[i]  <= div_den_reg[i-1];
                div_rem_reg[i]  <= div_rem_next[i-1];
                div_quo_reg[i]  <= div_quo_next[i-1];
            end

            f_chan_reg <= div_meta_reg[QUO_W].chan;
            f_word_reg <= f_word_next;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid entry
    assign out_take = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_vld_reg  <= skid_vld_reg || f_vld_reg;
            skid_vld_reg <= 1'b0;
        end
        else if (adv && f_vld_reg)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_chan_reg <= skid_vld_reg ? skid_chan_reg : f_chan_reg;
            out_word_reg <= skid_vld_reg ? skid_word_reg : f_word_reg;
        end
        else if (adv && f_vld_reg)
        begin
            skid_chan_reg <= f_chan_reg;
            skid_word_reg <= f_word_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_word_reg;
    assign m_axis_tuser  = out_chan_reg;

endmodule

// ===== hdl/vsc_checker.sv =====
// ----------------------------------------------------------------------------
// vsc_checker
// Port-level checks of the step command converter output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vsc_checker
    import vsc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [WORD_W-1:0] m_axis_tdata,
    input logic [CHAN_W-1:0] m_axis_tuser
);

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")

    // reserved word bits stay zero
    `ASSERT_CLK(a_reserved_zero, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[29:28] == 2'b00) && (m_axis_tdata[23:17] == 7'd0), "reserved command bits set")

    // enable clear means either the idle word or a saturated pause
    `ASSERT_CLK(a_disabled_form, clk, rst_n, m_axis_tvalid && !m_axis_tdata[30] |-> (m_axis_tdata[16:0] == 17'h1FFFF) || ((m_axis_tdata[16:0] == 17'd0) && !m_axis_tdata[31]), "disabled word neither idle nor saturated")

    // a moving command always carries a pulse length
    `ASSERT_CLK(a_motion_len, clk, rst_n, m_axis_tvalid && (m_axis_tdata[30] || m_axis_tdata[31]) |-> (m_axis_tdata[27:24] != 4'd0), "motion command with zero pulse length")

endmodule

bind velocity_to_step_command vsc_checker u_vsc_checker (.*);
